@@ hw/rtl/fvdsp_pkg.sv @@
// Shared types, constants and the per-voice step function of the delta sample player.
// Used by the player core, its port checker, the scoreboard and the testbench; depends on nothing else.
`default_nettype none

package fvdsp_pkg;

  localparam int SLOT_BYTES_DEF = 4096;
  localparam int SLOT_COUNT_DEF = 16;
  localparam int VOICES_DEF     = 4;

  localparam int MEM_DEPTH = 65536;
  localparam int MEM_AW    = 16;
  localparam int ADDR_W    = 17;
  localparam int LEN_W     = 13;
  localparam int SLOT_W    = 4;
  localparam int SLOT_CW   = 8;
  localparam int BUSY_W    = 4;

  localparam logic [1:0] FUNC_TRIGGER = 2'd0;
  localparam logic [1:0] FUNC_TICK    = 2'd1;
  localparam logic [1:0] FUNC_WRITE   = 2'd2;

  localparam logic [7:0] DAC_OFFSET = 8'h80;
  localparam logic [7:0] LEVEL_MAX  = 8'h7f;
  localparam logic [7:0] LEVEL_MIN  = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  typedef struct packed {
    logic              active;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] end_addr;
    logic [2:0]        bit_idx;
    logic [7:0]        level;
  } voice_t;

  // One delta bit for one voice; a voice that reaches its end is freed and zeroed.
  function automatic voice_t voice_step(voice_t v, logic [7:0] data);
    voice_t r;
    r = v;
    if (v.active) begin
      if (data[v.bit_idx]) begin
        r.level = v.level + 8'd1;
      end else begin
        r.level = v.level - 8'd1;
      end
      r.bit_idx = v.bit_idx + 3'd1;
      if (v.bit_idx == 3'd7) begin
        r.addr = v.addr + ADDR_W'(1);
      end
      if (r.addr == v.end_addr) begin
        r.active  = 1'b0;
        r.addr    = '0;
        r.bit_idx = '0;
        r.level   = '0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fvdsp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependencies.
`default_nettype none

module fvdsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/four_voice_delta_sample_player_core.sv @@
// Top level of the delta sample player: voice ring, tick sequencer and output register.
// Depends on fvdsp_pkg and fvdsp_ram.
`default_nettype none

// Trigger and memory-write items give no result. During an audio tick the voices rotate past
// the single read port of the 64 KiB sample memory, one voice per cycle, followed by a done
// state that saturates the mix and loads the output register once the output can take it.
// The core is stalled while a tick is in progress, but takes new items while a finished
// result still waits on the output.
module four_voice_delta_sample_player_core #(
  parameter int SLOT_BYTES = fvdsp_pkg::SLOT_BYTES_DEF,
  parameter int SLOT_COUNT = fvdsp_pkg::SLOT_COUNT_DEF,
  parameter int VOICES     = fvdsp_pkg::VOICES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [3:0]  in_sample_slot,
  input  wire logic [12:0] in_sample_length,
  input  wire logic [15:0] in_write_address,
  input  wire logic [7:0]  in_write_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_dac_value,
  output logic             out_dac_changed,
  output logic [3:0]       out_voices_busy
);

  localparam int VW       = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int NEXT_IDX = (VOICES > 1) ? 1 : 0;
  localparam int SHOW     = (VOICES < fvdsp_pkg::BUSY_W) ? VOICES : fvdsp_pkg::BUSY_W;
  localparam int SUM_W    = 8 + VW + 1;
  localparam logic [fvdsp_pkg::ADDR_W-1:0] SLOT_BYTES_A = fvdsp_pkg::ADDR_W'(SLOT_BYTES);
  localparam logic [fvdsp_pkg::LEN_W-1:0]  LEN_MAX      = fvdsp_pkg::LEN_W'(SLOT_BYTES);
  localparam logic [fvdsp_pkg::SLOT_CW-1:0] SLOT_LIM    = fvdsp_pkg::SLOT_CW'(SLOT_COUNT);

  fvdsp_pkg::state_t state_r, state_nxt;
  fvdsp_pkg::voice_t voices_r [VOICES];
  fvdsp_pkg::voice_t voices_nxt [VOICES];
  fvdsp_pkg::voice_t stepped;
  logic [VW-1:0]     vcnt_r, vcnt_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [7:0]        prev_dac_r, prev_dac_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_dac_r, out_dac_nxt;
  logic              out_chg_r, out_chg_nxt;
  logic [3:0]        out_busy_r, out_busy_nxt;

  logic              in_accept;
  logic              ram_we;
  logic [fvdsp_pkg::MEM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              free_found;
  logic [VW-1:0]     free_idx;
  logic              trig_ok;
  logic [fvdsp_pkg::LEN_W-1:0]  len_sat;
  logic [fvdsp_pkg::ADDR_W-1:0] base;
  logic [SUM_W-8:0]  sum_hi;
  logic [7:0]        mix;
  logic [7:0]        dac;
  logic [3:0]        busy;

  fvdsp_ram #(
    .WIDTH (8),
    .DEPTH (fvdsp_pkg::MEM_DEPTH),
    .AW    (fvdsp_pkg::MEM_AW)
  ) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_write_address),
    .wdata (in_write_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall        = (state_r != fvdsp_pkg::ST_IDLE);
  assign in_accept       = in_valid && !in_stall;
  assign out_valid       = out_valid_r;
  assign out_dac_value   = out_dac_r;
  assign out_dac_changed = out_chg_r;
  assign out_voices_busy = out_busy_r;

  assign stepped = fvdsp_pkg::voice_step(voices_r[0], ram_rdata);
  assign trig_ok = (fvdsp_pkg::SLOT_CW'(in_sample_slot) < SLOT_LIM) && (in_sample_length != '0);
  assign len_sat = (in_sample_length > LEN_MAX) ? LEN_MAX : in_sample_length;
  assign base    = fvdsp_pkg::ADDR_W'(in_sample_slot) * SLOT_BYTES_A;
  assign sum_hi  = sum_r[SUM_W-1:7];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!voices_r[i].active) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  always_comb begin
    if (sum_hi == '0 || sum_hi == '1) begin
      mix = sum_r[7:0];
    end else if (sum_r[SUM_W-1]) begin
      mix = fvdsp_pkg::LEVEL_MIN;
    end else begin
      mix = fvdsp_pkg::LEVEL_MAX;
    end
    dac  = mix ^ fvdsp_pkg::DAC_OFFSET;
    busy = '0;
    for (int i = 0; i < SHOW; i++) begin
      busy[i] = voices_r[i].active;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    voices_nxt    = voices_r;
    vcnt_nxt      = vcnt_r;
    sum_nxt       = sum_r;
    prev_dac_nxt  = prev_dac_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dac_nxt   = out_dac_r;
    out_chg_nxt   = out_chg_r;
    out_busy_nxt  = out_busy_r;
    ram_we        = 1'b0;
    ram_raddr     = (state_r == fvdsp_pkg::ST_IDLE) ? voices_r[0].addr[fvdsp_pkg::MEM_AW-1:0]
                                                    : voices_r[NEXT_IDX].addr[fvdsp_pkg::MEM_AW-1:0];
    case (state_r)
      fvdsp_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_func)
            fvdsp_pkg::FUNC_TRIGGER: begin
              if (trig_ok && free_found) begin
                voices_nxt[free_idx].active   = 1'b1;
                voices_nxt[free_idx].addr     = base;
                voices_nxt[free_idx].end_addr = base + fvdsp_pkg::ADDR_W'(len_sat);
                voices_nxt[free_idx].bit_idx  = '0;
                voices_nxt[free_idx].level    = '0;
              end
            end
            fvdsp_pkg::FUNC_TICK: begin
              state_nxt = fvdsp_pkg::ST_RUN;
              vcnt_nxt  = '0;
              sum_nxt   = '0;
            end
            fvdsp_pkg::FUNC_WRITE: begin
              ram_we = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      fvdsp_pkg::ST_RUN: begin
        for (int i = 0; i < VOICES - 1; i++) begin
          voices_nxt[i] = voices_r[i+1];
        end
        voices_nxt[VOICES-1] = stepped;
        sum_nxt  = sum_r + {{(SUM_W-8){stepped.level[7]}}, stepped.level};
        vcnt_nxt = vcnt_r + VW'(1);
        if (vcnt_r == VW'(VOICES - 1)) begin
          state_nxt = fvdsp_pkg::ST_DONE;
        end
      end
      fvdsp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dac_nxt   = dac;
          out_chg_nxt   = (dac != prev_dac_r);
          out_busy_nxt  = busy;
          prev_dac_nxt  = dac;
          state_nxt     = fvdsp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fvdsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fvdsp_pkg::ST_IDLE;
      vcnt_r      <= '0;
      sum_r       <= '0;
      prev_dac_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        voices_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      vcnt_r      <= vcnt_nxt;
      sum_r       <= sum_nxt;
      prev_dac_r  <= prev_dac_nxt;
      out_valid_r <= out_valid_nxt;
      voices_r    <= voices_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dac_r  <= out_dac_nxt;
    out_chg_r  <= out_chg_nxt;
    out_busy_r <= out_busy_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/fvdsp_checker.sv @@
// Port-level assertions for the delta sample player core, bound to the top level.
// Depends on fvdsp_pkg.
`default_nettype none

module fvdsp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_func,
  input wire logic [3:0]  in_sample_slot,
  input wire logic [12:0] in_sample_length,
  input wire logic [15:0] in_write_address,
  input wire logic [7:0]  in_write_data,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_dac_value,
  input wire logic        out_dac_changed,
  input wire logic [3:0]  out_voices_busy
);

  logic [7:0] last_dac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dac_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_dac_r <= out_dac_value;
    end
  end

  // A stalled input item holds.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_sample_slot)
      && $stable(in_sample_length) && $stable(in_write_address) && $stable(in_write_data))
    else $error("input item changed while stalled");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_dac_value)
      && $stable(out_dac_changed) && $stable(out_voices_busy))
    else $error("result item changed while stalled");

  // The change flag agrees with the last delivered DAC value.
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_dac_changed == (out_dac_value != last_dac_r))
    else $error("dac_changed inconsistent with previous item");

  // A tick keeps the input side stalled while the voices are stepped.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == fvdsp_pkg::FUNC_TICK |=> in_stall)
    else $error("input accepted during a tick");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind four_voice_delta_sample_player_core fvdsp_checker u_fvdsp_checker (.*);

`default_nettype wire

@@ dv/mix_check_pkg.sv @@
// Scoreboard for the four-voice delta sample player: a predictor of the voice ring and mix,
// and a queue of expected DAC results. Depends on fvdsp_pkg.
`timescale 1ns / 1ps

package mix_check_pkg;
  import fvdsp_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int MIX_HI = 127;
  localparam int MIX_LO = -128;

  typedef struct packed {
    logic [7:0]        dac;
    logic              changed;
    logic [BUSY_W-1:0] busy;
  } mix_result_t;

  class mix_scoreboard;
    bit [7:0]        mem [MEM_DEPTH];
    bit [ADDR_W-1:0] voice_addr [VOICES_DEF];
    bit [ADDR_W-1:0] voice_end [VOICES_DEF];
    bit [2:0]        voice_bit [VOICES_DEF];
    bit [7:0]        voice_level [VOICES_DEF];
    bit              voice_on [VOICES_DEF];
    bit [7:0]        last_dac;
    mix_result_t     expected_mix [$];
    int              errors;

    function void start_voice(bit [SLOT_W-1:0] slot, bit [LEN_W-1:0] len);
      int span;
      bit [ADDR_W-1:0] base;
      if (int'(slot) >= SLOT_COUNT_DEF || len == 0) return;
      span = (int'(len) > SLOT_BYTES_DEF) ? SLOT_BYTES_DEF : int'(len);
      base = ADDR_W'(int'(slot) * SLOT_BYTES_DEF);
      for (int v = 0; v < VOICES_DEF; v++) begin
        if (!voice_on[v]) begin
          voice_on[v]    = 1'b1;
          voice_addr[v]  = base;
          voice_end[v]   = ADDR_W'(int'(base) + span);
          voice_bit[v]   = '0;
          voice_level[v] = '0;
          return;
        end
      end
    endfunction

    function mix_result_t mix_voices();
      int mix;
      mix_result_t r;
      mix = 0;
      r.busy = '0;
      for (int v = 0; v < VOICES_DEF; v++) begin
        if (voice_on[v]) begin
          if (mem[voice_addr[v][MEM_AW-1:0]][voice_bit[v]]) begin
            voice_level[v] = voice_level[v] + 8'd1;
          end else begin
            voice_level[v] = voice_level[v] - 8'd1;
          end
          if (voice_bit[v] == 3'd7) begin
            voice_addr[v] = voice_addr[v] + ADDR_W'(1);
          end
          voice_bit[v] = voice_bit[v] + 3'd1;
          if (voice_addr[v] == voice_end[v]) begin
            voice_on[v]    = 1'b0;
            voice_addr[v]  = '0;
            voice_bit[v]   = '0;
            voice_level[v] = '0;
          end
          mix = mix + int'($signed(voice_level[v]));
        end
      end
      if (mix > MIX_HI) begin
        mix = MIX_HI;
      end else if (mix < MIX_LO) begin
        mix = MIX_LO;
      end
      r.dac = 8'(mix) ^ DAC_OFFSET;
      r.changed = (r.dac != last_dac);
      for (int v = 0; v < VOICES_DEF && v < BUSY_W; v++) begin
        r.busy[v] = voice_on[v];
      end
      last_dac = r.dac;
      return r;
    endfunction

    function void note_item(bit [1:0] func, bit [SLOT_W-1:0] slot, bit [LEN_W-1:0] len,
                            bit [MEM_AW-1:0] waddr, bit [7:0] wdata);
      case (func)
        FUNC_TRIGGER: start_voice(slot, len);
        FUNC_TICK: expected_mix.push_back(mix_voices());
        FUNC_WRITE: mem[waddr] = wdata;
        default: ;
      endcase
    endfunction

    function void check_result(bit [7:0] dac, bit changed, bit [BUSY_W-1:0] busy);
      mix_result_t want;
      if (expected_mix.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, dac_value %02h", $time, dac);
        return;
      end
      want = expected_mix.pop_front();
      if (want.dac != dac) begin
        errors++;
        $display("%0t: dac_value expected %02h, actual %02h", $time, want.dac, dac);
      end
      if (want.changed != changed) begin
        errors++;
        $display("%0t: dac_changed expected %0d, actual %0d", $time, want.changed, changed);
      end
      if (want.busy != busy) begin
        errors++;
        $display("%0t: voices_busy expected %04b, actual %04b", $time, want.busy, busy);
      end
    endfunction

    function int pending();
      return expected_mix.size();
    endfunction
  endclass

endpackage

@@ dv/tb.sv @@
// Testbench top for the four-voice delta sample player core: directed and random items with
// random idling on both sides, checked against mix_check_pkg. Depends on fvdsp_pkg, mix_check_pkg and the core.
`timescale 1ns / 1ps

module tb;
  import fvdsp_pkg::*;
  import mix_check_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 20;
  localparam int TOTAL_ITEMS    = 1350;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic [1:0]        in_func = '0;
  logic [SLOT_W-1:0] in_sample_slot = '0;
  logic [LEN_W-1:0]  in_sample_length = '0;
  logic [MEM_AW-1:0] in_write_address = '0;
  logic [7:0]        in_write_data = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [7:0]        out_dac_value;
  logic              out_dac_changed;
  logic [BUSY_W-1:0] out_voices_busy;

  mix_scoreboard sb;
  bit written [MEM_DEPTH];
  bit calm;
  int fill_mode;
  int items_sent;
  int idle_cycles;

  always #5 clk = ~clk;

  four_voice_delta_sample_player_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_sample_slot   (in_sample_slot),
    .in_sample_length (in_sample_length),
    .in_write_address (in_write_address),
    .in_write_data    (in_write_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dac_value    (out_dac_value),
    .out_dac_changed  (out_dac_changed),
    .out_voices_busy  (out_voices_busy)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_dac_value, out_dac_changed, out_voices_busy);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [7:0] fill_byte();
    case (fill_mode)
      0: return 8'hFF;
      1: return 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_item(logic [1:0] func, logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] len,
                           logic [MEM_AW-1:0] waddr, logic [7:0] wdata);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= func;
    in_sample_slot   <= slot;
    in_sample_length <= len;
    in_write_address <= waddr;
    in_write_data    <= wdata;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sb.note_item(func, slot, len, waddr, wdata);
    if (func == FUNC_WRITE) begin
      written[waddr] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic do_write(logic [MEM_AW-1:0] waddr, logic [7:0] wdata);
    send_item(FUNC_WRITE, SLOT_W'($urandom), LEN_W'($urandom), waddr, wdata);
  endtask

  task automatic do_trigger(logic [SLOT_W-1:0] slot, logic [LEN_W-1:0] len);
    send_item(FUNC_TRIGGER, slot, len, MEM_AW'($urandom), 8'($urandom));
  endtask

  // Every byte a playing voice is about to read is written first.
  task automatic do_tick();
    for (int v = 0; v < VOICES_DEF; v++) begin
      if (sb.voice_on[v] && !written[sb.voice_addr[v][MEM_AW-1:0]]) begin
        do_write(sb.voice_addr[v][MEM_AW-1:0], fill_byte());
      end
    end
    send_item(FUNC_TICK, SLOT_W'($urandom), LEN_W'($urandom), MEM_AW'($urandom),
              8'($urandom));
  endtask

  initial begin
    int pick;
    bit all_busy;
    logic [LEN_W-1:0] len;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    do_write(16'h0000, 8'hA5);
    do_write(16'hFFFF, 8'h5A);
    do_write(16'h1000, 8'hFF);
    do_trigger(4'd0, 13'd1);
    do_trigger(4'd0, 13'd0);
    send_item(FUNC_UNUSED, 4'hF, 13'h1FFF, 16'hFFFF, 8'hFF);
    do_trigger(4'd1, 13'd2);
    do_trigger(4'd2, 13'd3);
    do_trigger(4'd15, 13'h1FFF);
    do_trigger(4'd3, 13'd4096);
    repeat (9) do_tick();
    do_trigger(4'd14, 13'd1);
    repeat (4) do_tick();

    while (items_sent < TOTAL_ITEMS) begin
      calm = (items_sent >= 500) && (items_sent < 700);
      fill_mode = (items_sent / 200) % 3;
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_item(FUNC_UNUSED, SLOT_W'($urandom), LEN_W'($urandom), MEM_AW'($urandom),
                  8'($urandom));
      end else if (pick < 12) begin
        all_busy = 1'b1;
        for (int v = 0; v < VOICES_DEF; v++) begin
          if (!sb.voice_on[v]) all_busy = 1'b0;
        end
        pick = $urandom_range(99);
        if (all_busy) begin
          len = LEN_W'($urandom_range(8191));
        end else if (pick < 5) begin
          len = '0;
        end else if (pick < 75) begin
          len = LEN_W'($urandom_range(3, 1));
        end else if (pick < 95) begin
          len = LEN_W'($urandom_range(24, 4));
        end else begin
          len = LEN_W'($urandom_range(80, 25));
        end
        do_trigger(SLOT_W'($urandom_range(15)), len);
      end else if (pick < 25) begin
        do_write(MEM_AW'($urandom), 8'($urandom));
      end else begin
        do_tick();
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fvdsp_pkg.sv
hw/rtl/fvdsp_ram.sv
hw/rtl/four_voice_delta_sample_player_core.sv
hw/rtl/fvdsp_checker.sv
dv/mix_check_pkg.sv
dv/tb.sv
